[hdl/bpmc_pkg.sv]
// Package: types, constants and register map of the battery power-mode controller.
package bpmc_pkg;

  localparam int EVENT_DEPTH = 4;
  localparam int EV_PTR_W    = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int EV_CNT_W    = $clog2(EVENT_DEPTH + 1);

  localparam int MV_W    = 16;
  localparam int PCT_W   = 7;
  localparam int MS_W    = 32;
  localparam int NUM_W   = 24;
  localparam int DEN_W   = 17;
  localparam int Q_STEPS = 7;
  localparam int STEP_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MV       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_PCT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_LOW_PCT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_HIGH_PCT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REARM_PCT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STANDBY_MS    = 3'd6;

  localparam logic [MV_W-1:0]  RST_EMPTY_MV      = 16'd3300;
  localparam logic [MV_W-1:0]  RST_FULL_MV       = 16'd4200;
  localparam logic [PCT_W-1:0] RST_CRITICAL_PCT  = 7'd5;
  localparam logic [PCT_W-1:0] RST_WARN_LOW_PCT  = 7'd10;
  localparam logic [PCT_W-1:0] RST_WARN_HIGH_PCT = 7'd20;
  localparam logic [PCT_W-1:0] RST_REARM_PCT     = 7'd5;
  localparam logic [MS_W-1:0]  RST_STANDBY_MS    = 32'd300000;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef enum logic [1:0] {
    CMD_UPDATE   = 2'd0,
    CMD_ACTIVITY = 2'd1,
    CMD_POP      = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_ACTIVE   = 2'd0,
    MODE_STANDBY  = 2'd1,
    MODE_CRITICAL = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_WARN_HIGH = 2'd0,
    EV_WARN_LOW  = 2'd1,
    EV_CRITICAL  = 2'd2
  } ev_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [MS_W-1:0] now_ms;
    logic            battery_present;
    logic [MV_W-1:0] voltage_mv;
  } in_t;

  typedef struct packed {
    logic [1:0]       power_state;
    logic             battery_available;
    logic [PCT_W-1:0] battery_percent;
    logic [MV_W-1:0]  battery_voltage_mv;
    logic             event_valid;
    logic [1:0]       event_code;
    logic [2:0]       events_pending;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [PCT_W-1:0] quot;
  } div_sts_t;

endpackage

[hdl/bpmc_div.sv]
// Restoring divider, one quotient bit per cycle, for the charge percentage.
module bpmc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  bpmc_pkg::div_req_t  req,
  output bpmc_pkg::div_sts_t  sts
);

  logic                          busy_r, busy_nxt;
  logic [bpmc_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [bpmc_pkg::NUM_W-1:0]    rem_r, rem_nxt;
  logic [bpmc_pkg::NUM_W-1:0]    dsh_r, dsh_nxt;
  logic [bpmc_pkg::PCT_W-1:0]    quot_r, quot_nxt;
  logic [bpmc_pkg::NUM_W:0]      trial;
  logic                          qbit;

  assign trial = {1'b0, rem_r} - {1'b0, dsh_r};
  assign qbit  = ~trial[bpmc_pkg::NUM_W];

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = bpmc_pkg::STEP_W'(bpmc_pkg::Q_STEPS - 1);
      rem_nxt  = req.num;
      dsh_nxt  = bpmc_pkg::NUM_W'(req.den) << (bpmc_pkg::Q_STEPS - 1);
      quot_nxt = '0;
    end else if (busy_r) begin
      if (qbit) begin
        rem_nxt = trial[bpmc_pkg::NUM_W-1:0];
      end
      dsh_nxt  = dsh_r >> 1;
      quot_nxt = {quot_r[bpmc_pkg::PCT_W-2:0], qbit};
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = busy_r && (step_r == '0);
  assign sts.quot = {quot_r[bpmc_pkg::PCT_W-2:0], qbit};

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r == '0 && !req.start) |=> !busy_r)
    else $error("divider did not stop after last step");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r == '0) |-> (sts.quot <= bpmc_pkg::PCT_FULL))
    else $error("percentage above full scale");

endmodule

[hdl/battery_power_mode_controller_unit.sv]
// Top level: battery power-mode controller with percentage divider and event queue.
// Timing: an accepted beat is registered in item_r and passes ST_DIV (7-step divider)
//   if it is an update with battery present and a sample strictly between empty and
//   full, then ST_FINISH, then commits to the output register. A beat is taken only
//   in ST_IDLE; the output register lets the next beat enter while a result waits.
// Reset: synchronous active-low; mode active, latches and queue cleared, registers
//   at their default values. Queue entries hold no reset.
module battery_power_mode_controller_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bpmc_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bpmc_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [bpmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpmc_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

  // configuration
  logic [bpmc_pkg::MV_W-1:0]  empty_mv_r, full_mv_r;
  logic [bpmc_pkg::PCT_W-1:0] crit_pct_r, low_pct_r, high_pct_r, rearm_pct_r;
  logic [bpmc_pkg::MS_W-1:0]  timeout_r;

  // control state
  bpmc_pkg::state_t              state_r, state_nxt;
  bpmc_pkg::mode_t               mode_r, mode_nxt;
  logic [bpmc_pkg::MS_W-1:0]     last_r, last_nxt;
  logic                          crit_lat_r, crit_lat_nxt;
  logic                          low_lat_r, low_lat_nxt;
  logic                          high_lat_r, high_lat_nxt;
  logic                          have_r, have_nxt;
  logic [bpmc_pkg::PCT_W-1:0]    charge_r, charge_nxt;
  logic [bpmc_pkg::MV_W-1:0]     sample_r, sample_nxt;
  logic [bpmc_pkg::EV_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bpmc_pkg::EV_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bpmc_pkg::EV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // item payload
  bpmc_pkg::in_t                 item_r;
  logic [bpmc_pkg::PCT_W-1:0]    pct_r, pct_nxt;
  logic [1:0]                    ev_rd_r;
  bpmc_pkg::out_t                out_data_r, out_data_nxt;

  logic [1:0] ev_store [bpmc_pkg::EVENT_DEPTH];

  // handshake and datapath signals
  logic                        accept, commit, in_range, divide;
  logic [bpmc_pkg::MV_W-1:0]   span, offset;
  bpmc_pkg::div_req_t          div_req;
  bpmc_pkg::div_sts_t          div_sts;
  logic                        push;
  logic [1:0]                  push_code;

  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == bpmc_pkg::ST_FINISH) && (!out_valid_r || out_ready);
  assign in_range = (in_data.voltage_mv > empty_mv_r) && (in_data.voltage_mv < full_mv_r);
  assign divide   = (in_data.cmd == bpmc_pkg::CMD_UPDATE) && in_data.battery_present
                    && in_range;
  assign span     = full_mv_r - empty_mv_r;
  assign offset   = in_data.voltage_mv - empty_mv_r;

  assign div_req.start = accept && divide;
  assign div_req.num   = {1'b0, offset, 7'b0} + {2'b0, offset, 6'b0}
                       + {5'b0, offset, 3'b0} + {8'b0, span};
  assign div_req.den   = {span, 1'b0};

  bpmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpmc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = divide ? bpmc_pkg::ST_DIV : bpmc_pkg::ST_FINISH;
        end
      end
      bpmc_pkg::ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = bpmc_pkg::ST_FINISH;
        end
      end
      bpmc_pkg::ST_FINISH: begin
        if (commit) begin
          state_nxt = bpmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bpmc_pkg::ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == bpmc_pkg::ST_IDLE);

  // percentage select
  always_comb begin
    pct_nxt = pct_r;
    if (accept) begin
      pct_nxt = (in_data.voltage_mv <= empty_mv_r) ? '0 : bpmc_pkg::PCT_FULL;
    end else if ((state_r == bpmc_pkg::ST_DIV) && div_sts.done) begin
      pct_nxt = div_sts.quot;
    end
  end

  // item outcome
  always_comb begin
    logic [bpmc_pkg::PCT_W:0]  low_rearm, high_rearm, crit_rearm;
    logic [bpmc_pkg::MS_W-1:0] idle_ms;
    logic                      pop;
    mode_nxt      = mode_r;
    last_nxt      = last_r;
    crit_lat_nxt  = crit_lat_r;
    low_lat_nxt   = low_lat_r;
    high_lat_nxt  = high_lat_r;
    have_nxt      = have_r;
    charge_nxt    = charge_r;
    sample_nxt    = sample_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    cnt_nxt       = cnt_r;
    push          = 1'b0;
    push_code     = bpmc_pkg::EV_WARN_HIGH;
    pop           = 1'b0;
    idle_ms       = '0;
    low_rearm     = {1'b0, low_pct_r} + {1'b0, rearm_pct_r};
    high_rearm    = {1'b0, high_pct_r} + {1'b0, rearm_pct_r};
    crit_rearm    = {1'b0, crit_pct_r} + {1'b0, rearm_pct_r};
    out_valid_nxt = out_valid_r && !out_ready;
    case (item_r.cmd)
      bpmc_pkg::CMD_UPDATE: begin
        if (item_r.battery_present) begin
          have_nxt   = 1'b1;
          sample_nxt = item_r.voltage_mv;
          charge_nxt = pct_r;
          if (pct_r <= crit_pct_r) begin
            if (!crit_lat_r) begin
              crit_lat_nxt = 1'b1;
              push         = 1'b1;
              push_code    = bpmc_pkg::EV_CRITICAL;
              mode_nxt     = bpmc_pkg::MODE_CRITICAL;
            end
          end else if (pct_r <= low_pct_r) begin
            if (!low_lat_r) begin
              low_lat_nxt = 1'b1;
              push        = 1'b1;
              push_code   = bpmc_pkg::EV_WARN_LOW;
            end
          end else if (pct_r <= high_pct_r) begin
            if (!high_lat_r) begin
              high_lat_nxt = 1'b1;
              push         = 1'b1;
              push_code    = bpmc_pkg::EV_WARN_HIGH;
            end
          end
          if ({1'b0, pct_r} >= low_rearm) begin
            low_lat_nxt = 1'b0;
          end
          if ({1'b0, pct_r} >= high_rearm) begin
            high_lat_nxt = 1'b0;
          end
          if ((mode_nxt == bpmc_pkg::MODE_CRITICAL) && ({1'b0, pct_r} >= crit_rearm)) begin
            crit_lat_nxt = 1'b0;
            mode_nxt     = bpmc_pkg::MODE_ACTIVE;
            last_nxt     = item_r.now_ms;
          end
        end else begin
          have_nxt = 1'b0;
        end
        idle_ms = item_r.now_ms - last_nxt;
        if ((mode_nxt == bpmc_pkg::MODE_ACTIVE) && (idle_ms >= timeout_r)) begin
          mode_nxt = bpmc_pkg::MODE_STANDBY;
        end
      end
      bpmc_pkg::CMD_ACTIVITY: begin
        last_nxt = item_r.now_ms;
        if (mode_r == bpmc_pkg::MODE_STANDBY) begin
          mode_nxt = bpmc_pkg::MODE_ACTIVE;
        end
      end
      bpmc_pkg::CMD_POP: begin
        pop = (cnt_r != '0);
      end
      default: begin
      end
    endcase
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == bpmc_pkg::EV_PTR_W'(bpmc_pkg::EVENT_DEPTH - 1))
                   ? '0 : rd_ptr_r + 1'b1;
      cnt_nxt    = cnt_r - 1'b1;
    end
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == bpmc_pkg::EV_PTR_W'(bpmc_pkg::EVENT_DEPTH - 1))
                   ? '0 : wr_ptr_r + 1'b1;
      if (cnt_r == bpmc_pkg::EV_CNT_W'(bpmc_pkg::EVENT_DEPTH)) begin
        rd_ptr_nxt = (rd_ptr_r == bpmc_pkg::EV_PTR_W'(bpmc_pkg::EVENT_DEPTH - 1))
                     ? '0 : rd_ptr_r + 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    out_data_nxt.power_state        = mode_nxt;
    out_data_nxt.battery_available  = have_nxt;
    out_data_nxt.battery_percent    = charge_nxt;
    out_data_nxt.battery_voltage_mv = sample_nxt;
    out_data_nxt.event_valid        = pop;
    out_data_nxt.event_code         = pop ? ev_rd_r : 2'b0;
    out_data_nxt.events_pending     = 3'(cnt_nxt);
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_mv_r  <= bpmc_pkg::RST_EMPTY_MV;
      full_mv_r   <= bpmc_pkg::RST_FULL_MV;
      crit_pct_r  <= bpmc_pkg::RST_CRITICAL_PCT;
      low_pct_r   <= bpmc_pkg::RST_WARN_LOW_PCT;
      high_pct_r  <= bpmc_pkg::RST_WARN_HIGH_PCT;
      rearm_pct_r <= bpmc_pkg::RST_REARM_PCT;
      timeout_r   <= bpmc_pkg::RST_STANDBY_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        bpmc_pkg::REG_EMPTY_MV:      empty_mv_r  <= cfg_wdata[bpmc_pkg::MV_W-1:0];
        bpmc_pkg::REG_FULL_MV:       full_mv_r   <= cfg_wdata[bpmc_pkg::MV_W-1:0];
        bpmc_pkg::REG_CRITICAL_PCT:  crit_pct_r  <= cfg_wdata[bpmc_pkg::PCT_W-1:0];
        bpmc_pkg::REG_WARN_LOW_PCT:  low_pct_r   <= cfg_wdata[bpmc_pkg::PCT_W-1:0];
        bpmc_pkg::REG_WARN_HIGH_PCT: high_pct_r  <= cfg_wdata[bpmc_pkg::PCT_W-1:0];
        bpmc_pkg::REG_REARM_PCT:     rearm_pct_r <= cfg_wdata[bpmc_pkg::PCT_W-1:0];
        bpmc_pkg::REG_STANDBY_MS:    timeout_r   <= cfg_wdata[bpmc_pkg::MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpmc_pkg::ST_IDLE;
      mode_r      <= bpmc_pkg::MODE_ACTIVE;
      last_r      <= '0;
      crit_lat_r  <= 1'b0;
      low_lat_r   <= 1'b0;
      high_lat_r  <= 1'b0;
      have_r      <= 1'b0;
      charge_r    <= '0;
      sample_r    <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        mode_r     <= mode_nxt;
        last_r     <= last_nxt;
        crit_lat_r <= crit_lat_nxt;
        low_lat_r  <= low_lat_nxt;
        high_lat_r <= high_lat_nxt;
        have_r     <= have_nxt;
        charge_r   <= charge_nxt;
        sample_r   <= sample_nxt;
        rd_ptr_r   <= rd_ptr_nxt;
        wr_ptr_r   <= wr_ptr_nxt;
        cnt_r      <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    pct_r <= pct_nxt;
    if (accept) begin
      item_r  <= in_data;
      ev_rd_r <= ev_store[rd_ptr_r];
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && push) begin
      ev_store[wr_ptr_r] <= push_code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bpmc_pkg::EV_CNT_W'(bpmc_pkg::EVENT_DEPTH))
    else $error("event count above queue depth");

  a_crit_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == bpmc_pkg::MODE_CRITICAL) |-> crit_lat_r)
    else $error("critical mode without critical latch");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input taken twice in a row");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> (state_r == bpmc_pkg::ST_DIV))
    else $error("divider running outside divide state");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && out_data_nxt.event_valid) |-> (cnt_r != '0))
    else $error("event popped from empty queue");

endmodule
